### rtl/midpoint_interpolator_2x_unit_defines.svh
// Assertion macros for the midpoint interpolator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIDPOINT_INTERPOLATOR_2X_UNIT_DEFINES_SVH
`define MIDPOINT_INTERPOLATOR_2X_UNIT_DEFINES_SVH

// Clocked property, masked while reset is held.
`define MPI_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) prop) else $error(msg);

// Clocked property, also checked across reset.
`define MPI_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge aclk) \
    prop) else $error(msg);

`endif

### rtl/mpi_pkg.sv
// Shared types, constants and coefficient table of the midpoint interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mpi_pkg;

    localparam int ORDER       = 8;
    localparam int MAX_ROW     = 4096;
    localparam int SAMPLE_BITS = 32;

    localparam int KT        = (ORDER / 2) * 2;
    localparam int HALF      = KT / 2;
    localparam int POS_W     = 13;
    localparam int POS_LIMIT = MAX_ROW + 8;
    localparam int NOUT      = 3;
    localparam int CNT_W     = $clog2(NOUT + 1);
    localparam int COEF_W    = 12;
    localparam int FRAC_BITS = 11;
    localparam int PROD_W    = SAMPLE_BITS + 1 + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_LAST  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [KT-1:0][SAMPLE_BITS-1:0] window_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    localparam coef_t COEF_TAB [4][4] = '{
        '{12'sd1024, 12'sd0,    12'sd0,  12'sd0},
        '{12'sd1152, -12'sd128, 12'sd0,  12'sd0},
        '{12'sd1200, -12'sd200, 12'sd24, 12'sd0},
        '{12'sd1225, -12'sd245, 12'sd49, -12'sd5}
    };

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t SAT_HI = {{(ACC_W - SAMPLE_BITS + 1){1'b0}},
                               {(SAMPLE_BITS - 1){1'b1}}};
    localparam acc_t SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic emit_copy;
        logic emit_mid;
        logic emit_extra;
        logic row_end;
    } job_t;

    typedef struct packed {
        acc_t    acc;
        sample_t copy;
        sample_t extra;
        job_t    flags;
    } mac_t;

    typedef struct packed {
        sample_t sample;
        logic    is_mid;
        logic    row_end;
    } entry_t;

endpackage

`default_nettype wire

### rtl/mpi_window.sv
// Tap window, row position and per-sample emission decision.
// Depends on mpi_pkg.
`default_nettype none

module mpi_window import mpi_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_fire,
    input  wire sample_t in_sample,
    input  wire logic    in_row_end,
    input  wire logic    skip_first,
    input  wire logic    skip_last,
    input  wire logic    job_take,
    output logic         job_valid,
    output job_t         job,
    output window_t      window
);

    window_t           tap_reg;
    window_t           tap_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              job_valid_reg;
    logic              job_valid_next;
    job_t              job_reg;
    job_t              job_next;

    always_comb begin
        for (int k = 0; k < KT - 1; k++) begin
            tap_next[k] = tap_reg[k + 1];
        end
        tap_next[KT-1] = in_sample;

        job_next.emit_mid   = (pos_reg >= POS_W'(KT - 1));
        job_next.emit_copy  = job_next.emit_mid &&
                              !((pos_reg == POS_W'(KT - 1)) && skip_first);
        job_next.emit_extra = in_row_end && skip_last &&
                              (pos_reg >= POS_W'(KT - 2)) &&
                              !((pos_reg == POS_W'(KT - 2)) && skip_first);
        job_next.row_end    = in_row_end;

        if (in_row_end) begin
            pos_next = '0;
        end else if (pos_reg < POS_W'(POS_LIMIT)) begin
            pos_next = pos_reg + POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end

        if (in_fire) begin
            job_valid_next = job_next.emit_copy || job_next.emit_mid ||
                             job_next.emit_extra;
        end else if (job_take) begin
            job_valid_next = 1'b0;
        end else begin
            job_valid_next = job_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            if (in_fire) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            tap_reg <= tap_next;
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign window    = tap_reg;

endmodule

`default_nettype wire

### rtl/mpi_mac.sv
// Symmetric constant-coefficient sum over the tap window, one registered stage.
// Depends on mpi_pkg.
`default_nettype none

module mpi_mac import mpi_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    job_valid,
    input  wire job_t    job,
    input  wire window_t window,
    input  wire logic    load_ok,
    output logic         mac_ready,
    output logic         mac_valid,
    output mac_t         mac
);

    logic                          mac_valid_reg;
    mac_t                          mac_reg;
    mac_t                          mac_next;
    logic signed [SAMPLE_BITS:0]   pair;
    logic signed [PROD_W-1:0]      prod;
    acc_t                          acc;

    always_comb begin
        acc = '0;
        for (int k = 0; k < HALF; k++) begin
            pair = {window[HALF-1-k][SAMPLE_BITS-1], window[HALF-1-k]} +
                   {window[HALF+k][SAMPLE_BITS-1], window[HALF+k]};
            prod = pair * COEF_TAB[HALF-1][k];
            acc  = acc + ACC_W'(prod);
        end
        mac_next.acc   = acc;
        mac_next.copy  = sample_t'(window[HALF-1]);
        mac_next.extra = sample_t'(window[HALF]);
        mac_next.flags = job;
    end

    assign mac_ready = !mac_valid_reg || load_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_valid_reg <= 1'b0;
        end else if (mac_ready) begin
            mac_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_ready && job_valid) begin
            mac_reg <= mac_next;
        end
    end

    assign mac_valid = mac_valid_reg;
    assign mac       = mac_reg;

endmodule

`default_nettype wire

### rtl/mpi_queue.sv
// Rounding, saturation and the three-entry result queue on the output side.
// Depends on mpi_pkg.
`default_nettype none

module mpi_queue import mpi_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  mac_valid,
    input  wire mac_t  mac,
    output logic       load_ok,
    output logic       out_valid,
    input  wire logic  out_ready,
    output entry_t     out_entry
);

    entry_t            ent_reg  [NOUT];
    entry_t            ent_next [NOUT];
    entry_t            new_ent  [NOUT];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  n;
    logic              pop;
    logic              load;
    acc_t              rnd;
    acc_t              quo;
    sample_t           mid_val;

    always_comb begin
        rnd = mac.acc + ROUND_HALF;
        quo = rnd >>> FRAC_BITS;
        if (quo > SAT_HI) begin
            mid_val = sample_t'(SAT_HI);
        end else if (quo < SAT_LO) begin
            mid_val = sample_t'(SAT_LO);
        end else begin
            mid_val = sample_t'(quo);
        end

        for (int i = 0; i < NOUT; i++) begin
            new_ent[i] = '0;
        end
        n = '0;
        if (mac.flags.emit_copy) begin
            new_ent[n[1:0]] = '{sample: mac.copy, is_mid: 1'b0, row_end: 1'b0};
            n = n + CNT_W'(1);
        end
        if (mac.flags.emit_mid) begin
            new_ent[n[1:0]] = '{sample: mid_val, is_mid: 1'b1, row_end: 1'b0};
            n = n + CNT_W'(1);
        end
        if (mac.flags.emit_extra) begin
            new_ent[n[1:0]] = '{sample: mac.extra, is_mid: 1'b0, row_end: 1'b0};
            n = n + CNT_W'(1);
        end
        if (mac.flags.row_end && (n != '0)) begin
            new_ent[n[1:0] - 2'd1].row_end = 1'b1;
        end
    end

    assign pop     = (cnt_reg != '0) && out_ready;
    assign load_ok = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && pop);
    assign load    = mac_valid && load_ok;

    always_comb begin
        for (int i = 0; i < NOUT; i++) begin
            ent_next[i] = ent_reg[i];
        end
        cnt_next = cnt_reg;
        if (load) begin
            for (int i = 0; i < NOUT; i++) begin
                ent_next[i] = new_ent[i];
            end
            cnt_next = n;
        end else if (pop) begin
            for (int i = 0; i < NOUT - 1; i++) begin
                ent_next[i] = ent_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NOUT; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_entry = ent_reg[0];

endmodule

`default_nettype wire

### rtl/midpoint_interpolator_2x_unit.sv
// Top level of the two-times row upsampler with symmetric Lagrange midpoints.
// Depends on mpi_pkg, mpi_window, mpi_mac and mpi_queue.
//
// Usage:
//   s_ channel: one padded row sample per transfer, halo included; s_tlast
//   marks the last sample of a row. m_ channel: fine-grid results, copy then
//   midpoint per centre; m_tuser is 1 for a midpoint, m_tlast marks the last
//   result of the row. cfg_ channel writes skip_first (index 0) and
//   skip_last (index 1); cfg_ready is always high; write only while idle.
//   An input transfer loads the window stage; the results of a sample then
//   pass through the sum stage and the queue before showing on m_tvalid.
//   Throughput: one result per cycle on m_ while m_tready is high; the queue
//   takes a new sample's results only when it is empty or its last entry is
//   being taken, so a sample yielding several results holds the input back.
//   Input is taken every cycle while the row is still filling the window, unless a stall still holds the stages.
//   Reset (aresetn low, synchronous) empties all stages, clears the row
//   position and both skip flags. When m_tready is low the queue holds its
//   head, the sum and window stages fill, then s_tready drops.
`default_nettype none

module midpoint_interpolator_2x_unit import mpi_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // [31:0] in_sample
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // [31:0] out_sample
    output logic                      m_tuser,   // [0] out_is_midpoint
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic                 cfg_data
);

    logic    skip_first_reg;
    logic    skip_last_reg;
    logic    in_fire;
    logic    job_valid;
    job_t    job;
    window_t window;
    logic    mac_ready;
    logic    mac_valid;
    mac_t    mac;
    logic    load_ok;
    entry_t  out_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_first_reg <= 1'b0;
            skip_last_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SKIP_FIRST: skip_first_reg <= cfg_data;
                REG_SKIP_LAST:  skip_last_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !job_valid || mac_ready;
    assign in_fire  = s_tvalid && s_tready;

    mpi_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_sample  (sample_t'(s_tdata)),
        .in_row_end (s_tlast),
        .skip_first (skip_first_reg),
        .skip_last  (skip_last_reg),
        .job_take   (mac_ready),
        .job_valid  (job_valid),
        .job        (job),
        .window     (window)
    );

    mpi_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .window    (window),
        .load_ok   (load_ok),
        .mac_ready (mac_ready),
        .mac_valid (mac_valid),
        .mac       (mac)
    );

    mpi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mac_valid (mac_valid),
        .mac       (mac),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry)
    );

    assign m_tdata = 32'(out_entry.sample);
    assign m_tuser = out_entry.is_mid;
    assign m_tlast = out_entry.row_end;

endmodule

`default_nettype wire

### rtl/mpi_checker.sv
// Port-level checker for the midpoint interpolator, bound to the top level.
// Depends on mpi_pkg and midpoint_interpolator_2x_unit_defines.svh.
`default_nettype none
`include "midpoint_interpolator_2x_unit_defines.svh"

module mpi_checker import mpi_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `MPI_ASSERT(a_m_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `MPI_ASSERT(a_m_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `MPI_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid, "result pending after reset")
    `MPI_ASSERT_RST(a_rst_ready, !aresetn |=> s_tready, "input not ready after reset")

endmodule

bind midpoint_interpolator_2x_unit mpi_checker u_mpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
